// ===== rtl/core/cbsp_pkg.sv =====
package cbsp_pkg;

    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int STEPS_W = 6;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd15;

    localparam int T_FRAC = 16;
    localparam int T_W    = T_FRAC + 1;
    localparam int BIT_W  = $clog2(T_W);

    localparam int TAG_W = 4;

    typedef struct packed {
        logic start;
        logic advance;
    } t_tgen_ctl;

endpackage

// ===== rtl/core/cbsp_lerp.sv =====
module cbsp_lerp #(
    parameter int COORD_WIDTH = cbsp_pkg::DEF_COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [cbsp_pkg::TAG_W-1:0]      i_tag,
    input  logic signed [COORD_WIDTH-1:0]   i_a,
    input  logic signed [COORD_WIDTH-1:0]   i_b,
    input  logic [cbsp_pkg::T_W-1:0]        i_t,
    output logic                            o_valid,
    output logic [cbsp_pkg::TAG_W-1:0]      o_tag,
    output logic signed [COORD_WIDTH-1:0]   o_res
);
    import cbsp_pkg::*;

    localparam int PROD_W = COORD_WIDTH + T_W + 2;

    logic signed [COORD_WIDTH:0]   diff;
    logic signed [T_W:0]           t_s;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [COORD_WIDTH-1:0] r_a;
    logic [TAG_W-1:0]              r_tag;
    logic                          r_valid;
    logic signed [PROD_W-1:0]      shifted;
    logic signed [PROD_W-1:0]      a_ext;
    logic signed [PROD_W-1:0]      res_full;

    assign diff = {i_a[COORD_WIDTH-1], i_a} - {i_b[COORD_WIDTH-1], i_b};
    assign t_s  = {1'b0, i_t};
    assign prod = diff * t_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prod <= prod;
        r_a    <= i_a;
        r_tag  <= i_tag;
    end

    // The arithmetic shift gives the floor of the scaled product.
    assign shifted  = r_prod >>> T_FRAC;
    assign a_ext    = {{(PROD_W - COORD_WIDTH){r_a[COORD_WIDTH-1]}}, r_a};
    assign res_full = a_ext - shifted;

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_res   = res_full[COORD_WIDTH-1:0];

endmodule

// ===== rtl/core/cbsp_tgen.sv =====
module cbsp_tgen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbsp_pkg::t_tgen_ctl           i_ctl,
    input  logic [cbsp_pkg::STEPS_W-1:0]  i_count,
    output logic                          o_div_busy,
    output logic [cbsp_pkg::T_W-1:0]      o_t
);
    import cbsp_pkg::*;

    logic [STEPS_W-1:0] r_count;
    logic [BIT_W-1:0]   r_bit;
    logic [STEPS_W-1:0] r_rem;
    logic [T_W-1:0]     r_q;
    logic [STEPS_W-1:0] r_acc;
    logic [T_W-1:0]     r_t;
    logic               r_div_busy;

    logic               dbit;
    logic [STEPS_W:0]   trial;
    logic               trial_ge;
    logic [STEPS_W:0]   trial_sub;
    logic [STEPS_W:0]   sum;
    logic               sum_ge;
    logic [STEPS_W:0]   sum_sub;

    // Restoring division of one full turn of t by the step count, one bit per cycle.
    assign dbit      = (r_bit == BIT_W'(T_FRAC));
    assign trial     = {r_rem, dbit};
    assign trial_ge  = (trial >= {1'b0, r_count});
    assign trial_sub = trial - {1'b0, r_count};

    // Per step, t grows by the quotient plus a carry from the remainder accumulator.
    assign sum     = {1'b0, r_acc} + {1'b0, r_rem};
    assign sum_ge  = (sum >= {1'b0, r_count});
    assign sum_sub = sum - {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_count    <= i_count;
            r_bit      <= BIT_W'(T_FRAC);
            r_rem      <= '0;
            r_q        <= '0;
            r_acc      <= '0;
            r_t        <= '0;
            r_div_busy <= 1'b1;
        end else if (r_div_busy) begin
            r_q   <= {r_q[T_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[STEPS_W-1:0] : trial[STEPS_W-1:0];
            if (r_bit == '0) begin
                r_div_busy <= 1'b0;
            end else begin
                r_bit <= r_bit - 1'b1;
            end
        end else if (i_ctl.advance) begin
            r_t   <= r_t + r_q + T_W'(sum_ge);
            r_acc <= sum_ge ? sum_sub[STEPS_W-1:0] : sum[STEPS_W-1:0];
        end
    end

    assign o_div_busy = r_div_busy;
    assign o_t        = r_t;

endmodule

// ===== rtl/core/cubic_bezier_segment_points.sv =====
// An accepted transaction first finds the parameter step with a bit-serial division, then
// emits its count + 1 points one after another. A new segment is accepted only when the
// previous one has emitted its last point; all twelve interpolations of each point run
// in turn on the one shared interpolation unit.
// Reset is synchronous and active low; the step count returns to 15 and the block is idle.
module cubic_bezier_segment_points #(
    parameter int MAX_POINTS  = cbsp_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = cbsp_pkg::DEF_COORD_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [cbsp_pkg::STEPS_W-1:0]   i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p3_y,
    output logic                           o_strobe,
    output logic signed [COORD_WIDTH-1:0]  o_x,
    output logic signed [COORD_WIDTH-1:0]  o_y,
    output logic                           o_last
);
    import cbsp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EVAL
    } t_state;

    localparam logic [STEPS_W-1:0] MAX_CNT = STEPS_W'(MAX_POINTS - 1);

    localparam logic [TAG_W-1:0] K_AX0  = 4'd0;
    localparam logic [TAG_W-1:0] K_AX1  = 4'd1;
    localparam logic [TAG_W-1:0] K_AX2  = 4'd2;
    localparam logic [TAG_W-1:0] K_AY0  = 4'd3;
    localparam logic [TAG_W-1:0] K_AY1  = 4'd4;
    localparam logic [TAG_W-1:0] K_AY2  = 4'd5;
    localparam logic [TAG_W-1:0] K_BX0  = 4'd6;
    localparam logic [TAG_W-1:0] K_BX1  = 4'd7;
    localparam logic [TAG_W-1:0] K_BY0  = 4'd8;
    localparam logic [TAG_W-1:0] K_BY1  = 4'd9;
    localparam logic [TAG_W-1:0] K_X    = 4'd10;
    localparam logic [TAG_W-1:0] K_Y    = 4'd11;
    localparam logic [TAG_W-1:0] K_EMIT = 4'd12;

    t_state                  r_state;
    logic [STEPS_W-1:0]      r_steps;
    logic [STEPS_W-1:0]      r_count;
    logic [STEPS_W-1:0]      r_j;
    logic [TAG_W-1:0]        r_k;
    logic signed [COORD_WIDTH-1:0] r_cx [0:3];
    logic signed [COORD_WIDTH-1:0] r_cy [0:3];
    logic signed [COORD_WIDTH-1:0] r_ax [0:2];
    logic signed [COORD_WIDTH-1:0] r_ay [0:2];
    logic signed [COORD_WIDTH-1:0] r_bx [0:1];
    logic signed [COORD_WIDTH-1:0] r_by [0:1];

    logic [STEPS_W-1:0]      n_count;
    logic                    accept;
    t_tgen_ctl               tgen_ctl;
    logic                    div_busy;
    logic [T_W-1:0]          t_cur;
    logic                    issue;
    logic signed [COORD_WIDTH-1:0] op_a;
    logic signed [COORD_WIDTH-1:0] op_b;
    logic                    l_valid;
    logic [TAG_W-1:0]        l_tag;
    logic signed [COORD_WIDTH-1:0] l_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign issue  = (r_state == S_EVAL) && (r_k != K_EMIT);

    always_comb begin
        if (r_steps == '0) begin
            n_count = STEPS_W'(1);
        end else if (r_steps > MAX_CNT) begin
            n_count = MAX_CNT;
        end else begin
            n_count = r_steps;
        end
    end

    assign tgen_ctl.start   = accept;
    assign tgen_ctl.advance = (r_state == S_EVAL) && (r_k == K_EMIT);

    cbsp_tgen u_tgen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tgen_ctl),
        .i_count    (n_count),
        .o_div_busy (div_busy),
        .o_t        (t_cur)
    );

    always_comb begin
        case (r_k)
            K_AX0:   begin op_a = r_cx[0]; op_b = r_cx[1]; end
            K_AX1:   begin op_a = r_cx[1]; op_b = r_cx[2]; end
            K_AX2:   begin op_a = r_cx[2]; op_b = r_cx[3]; end
            K_AY0:   begin op_a = r_cy[0]; op_b = r_cy[1]; end
            K_AY1:   begin op_a = r_cy[1]; op_b = r_cy[2]; end
            K_AY2:   begin op_a = r_cy[2]; op_b = r_cy[3]; end
            K_BX0:   begin op_a = r_ax[0]; op_b = r_ax[1]; end
            K_BX1:   begin op_a = r_ax[1]; op_b = r_ax[2]; end
            K_BY0:   begin op_a = r_ay[0]; op_b = r_ay[1]; end
            K_BY1:   begin op_a = r_ay[1]; op_b = r_ay[2]; end
            K_X:     begin op_a = r_bx[0]; op_b = r_bx[1]; end
            K_Y:     begin op_a = r_by[0]; op_b = r_by[1]; end
            default: begin op_a = r_by[0]; op_b = r_by[1]; end
        endcase
    end

    cbsp_lerp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_tag   (r_k),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_t     (t_cur),
        .o_valid (l_valid),
        .o_tag   (l_tag),
        .o_res   (l_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_steps  <= STEPS_RESET;
            o_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_steps <= i_cfg_data;
            end
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cx[0] <= i_p0_x;
                        r_cx[1] <= i_p1_x;
                        r_cx[2] <= i_p2_x;
                        r_cx[3] <= i_p3_x;
                        r_cy[0] <= i_p0_y;
                        r_cy[1] <= i_p1_y;
                        r_cy[2] <= i_p2_y;
                        r_cy[3] <= i_p3_y;
                        r_count <= n_count;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_k == K_EMIT) begin
                        o_strobe <= 1'b1;
                        o_last   <= (r_j == r_count);
                        r_k      <= '0;
                        r_j      <= r_j + 1'b1;
                        if (r_j == r_count) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (l_valid) begin
                case (l_tag)
                    K_AX0:   r_ax[0] <= l_res;
                    K_AX1:   r_ax[1] <= l_res;
                    K_AX2:   r_ax[2] <= l_res;
                    K_AY0:   r_ay[0] <= l_res;
                    K_AY1:   r_ay[1] <= l_res;
                    K_AY2:   r_ay[2] <= l_res;
                    K_BX0:   r_bx[0] <= l_res;
                    K_BX1:   r_bx[1] <= l_res;
                    K_BY0:   r_by[0] <= l_res;
                    K_BY1:   r_by[1] <= l_res;
                    K_X:     o_x     <= l_res;
                    K_Y:     o_y     <= l_res;
                    default: o_y     <= l_res;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_ends_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("last point shown while the segment is still in progress");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("accepted transaction did not make the block busy");

    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two points on consecutive cycles");
`endif

endmodule

// ===== dv/cbsp_point_checker.sv =====
module cbsp_point_checker #(
    parameter int MAX_POINTS  = cbsp_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = cbsp_pkg::DEF_COORD_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_seg_start,
    input  logic                           i_seg_busy,
    input  logic                           i_cfg_we,
    input  logic [cbsp_pkg::STEPS_W-1:0]   i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p3_y,
    input  logic                           i_strobe,
    input  logic signed [COORD_WIDTH-1:0]  i_x,
    input  logic signed [COORD_WIDTH-1:0]  i_y,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_points_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          last;
    } curve_point_t;

    curve_point_t expected_points[$];
    int           step_count;

    function automatic longint lerp_q16(longint a, longint b, longint t);
        return a - (((a - b) * t) >>> 16);
    endfunction

    function automatic longint bezier_coord(longint c0, longint c1, longint c2, longint c3,
                                            longint t);
        longint a0, a1, a2, b0, b1;
        a0 = lerp_q16(c0, c1, t);
        a1 = lerp_q16(c1, c2, t);
        a2 = lerp_q16(c2, c3, t);
        b0 = lerp_q16(a0, a1, t);
        b1 = lerp_q16(a1, a2, t);
        return lerp_q16(b0, b1, t);
    endfunction

    task automatic predict_segment();
        int           steps;
        longint       t;
        curve_point_t pt;
        steps = (step_count == 0) ? 1 : step_count;
        if (steps > MAX_POINTS - 1) begin
            steps = MAX_POINTS - 1;
        end
        for (int j = 0; j <= steps; j++) begin
            t       = (longint'(j) * 65536) / steps;
            pt.x    = COORD_WIDTH'(bezier_coord(i_p0_x, i_p1_x, i_p2_x, i_p3_x, t));
            pt.y    = COORD_WIDTH'(bezier_coord(i_p0_y, i_p1_y, i_p2_y, i_p3_y, t));
            pt.last = (j == steps);
            expected_points.push_back(pt);
        end
    endtask

    task automatic check_point();
        curve_point_t pt;
        if (expected_points.size() == 0) begin
            if (o_fail_count < 10) begin
                $display("%0t: unexpected point x=%0d y=%0d last=%0b", $realtime, i_x, i_y,
                         i_last);
            end
            o_fail_count++;
        end else begin
            pt = expected_points.pop_front();
            if (i_x !== pt.x || i_y !== pt.y || i_last !== pt.last) begin
                if (o_fail_count < 10) begin
                    $display("%0t: point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                             $realtime, pt.x, pt.y, pt.last, i_x, i_y, i_last);
                end
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count     = 0;
        o_points_pending = 0;
        step_count       = cbsp_pkg::STEPS_RESET;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_count = cbsp_pkg::STEPS_RESET;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                step_count = i_cfg_data;
            end
            if (i_seg_start && !i_seg_busy) begin
                predict_segment();
            end
            if (i_strobe) begin
                check_point();
            end
        end
        o_points_pending = expected_points.size();
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = cbsp_pkg::DEF_COORD_WIDTH;
    localparam logic signed [CW-1:0] CMIN = -32768;
    localparam logic signed [CW-1:0] CMAX = 32767;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_cfg_we;
    logic [cbsp_pkg::STEPS_W-1:0]  i_cfg_data;
    logic signed [CW-1:0]          i_p0_x, i_p0_y, i_p1_x, i_p1_y;
    logic signed [CW-1:0]          i_p2_x, i_p2_y, i_p3_x, i_p3_y;
    logic                          o_strobe;
    logic signed [CW-1:0]          o_x, o_y;
    logic                          o_last;
    int                            fail_count;
    int                            points_pending;
    bit                            no_idle;

    cubic_bezier_segment_points u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_p0_x     (i_p0_x),
        .i_p0_y     (i_p0_y),
        .i_p1_x     (i_p1_x),
        .i_p1_y     (i_p1_y),
        .i_p2_x     (i_p2_x),
        .i_p2_y     (i_p2_y),
        .i_p3_x     (i_p3_x),
        .i_p3_y     (i_p3_y),
        .o_strobe   (o_strobe),
        .o_x        (o_x),
        .o_y        (o_y),
        .o_last     (o_last)
    );

    cbsp_point_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_seg_start      (start),
        .i_seg_busy       (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_p0_x           (i_p0_x),
        .i_p0_y           (i_p0_y),
        .i_p1_x           (i_p1_x),
        .i_p1_y           (i_p1_y),
        .i_p2_x           (i_p2_x),
        .i_p2_y           (i_p2_y),
        .i_p3_x           (i_p3_x),
        .i_p3_y           (i_p3_y),
        .i_strobe         (o_strobe),
        .i_x              (o_x),
        .i_y              (o_y),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                return CMIN;
            end
            1: begin
                return CMAX;
            end
            2: begin
                return CW'($urandom_range(0, 64)) - CW'(32);
            end
            default: begin
                return CW'($urandom);
            end
        endcase
    endfunction

    task automatic send_segment(logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
                                logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                                logic signed [CW-1:0] x2, logic signed [CW-1:0] y2,
                                logic signed [CW-1:0] x3, logic signed [CW-1:0] y3);
        @(negedge i_clk);
        while (busy) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_p0_x <= x0;
        i_p0_y <= y0;
        i_p1_x <= x1;
        i_p1_y <= y1;
        i_p2_x <= x2;
        i_p2_y <= y2;
        i_p3_x <= x3;
        i_p3_y <= y3;
        @(posedge i_clk);
    endtask

    task automatic send_random_segment();
        send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (points_pending != 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_steps(int value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cbsp_pkg::STEPS_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int phase_steps[10];
        int steps;
        int items;
        phase_steps = '{0, 1, 2, 63, 3, 7, 15, 31, -1, 1};
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_p0_x     = '0;
        i_p0_y     = '0;
        i_p1_x     = '0;
        i_p1_y     = '0;
        i_p2_x     = '0;
        i_p2_y     = '0;
        i_p3_x     = '0;
        i_p3_y     = '0;
        no_idle    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The reset step count is used for the first segments.
        send_segment('0, '0, '0, '0, '0, '0, '0, '0);
        send_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_segment(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_segment(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
        send_segment(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
        send_segment(CMAX, '0, '0, CMAX, '0, CMIN, CMIN, '0);
        send_segment(-16384, -16384, -5461, -5461, 5461, 5461, 16384, 16384);
        send_segment(1, -1, -1, 1, 1, -1, -1, 1);
        repeat (3) send_random_segment();

        // A zero step count behaves as one step.
        write_steps(0);
        send_segment(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
        send_random_segment();
        write_steps(63);
        send_segment(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
        send_random_segment();
        write_steps(1);
        send_segment(CMAX, CMIN, '0, '0, '0, '0, CMIN, CMAX);
        send_random_segment();

        for (int p = 0; p < 10; p++) begin
            steps = (phase_steps[p] < 0) ? $urandom_range(1, 12) : phase_steps[p];
            items = (steps >= 63) ? 14 : (steps >= 31) ? 20 : 44;
            write_steps(steps);
            no_idle = (p == 6);
            repeat (items) send_random_segment();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && points_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== cubic_bezier_segment_points.f =====
rtl/core/cbsp_pkg.sv
rtl/core/cbsp_lerp.sv
rtl/core/cbsp_tgen.sv
rtl/core/cubic_bezier_segment_points.sv
dv/cbsp_point_checker.sv
dv/tb.sv
